### rtl/positional_char_list_defines.svh
// Assertion macros shared by the positional character list RTL.
`ifndef POSITIONAL_CHAR_LIST_DEFINES_SVH
`define POSITIONAL_CHAR_LIST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pcl_pkg.sv
// Shared types and constants for the positional character list.
package pcl_pkg;

    localparam int CAP_DEFAULT = 32;
    localparam int POS_W       = 6;
    localparam int VAL_W       = 8;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_GET    = 2'd2,
        MODE_PRINT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_ELEM   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Work the back end carries out for one classified request.
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_GET    = 3'd2,
        OP_PRINT  = 3'd3,
        OP_STATUS = 3'd4
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] slot;
        logic [VAL_W-1:0] value;
        status_t          status;
    } cmd_t;

endpackage

### rtl/pcl_front.sv
// Request classifier: range and fill checks against a shadow entry count.
module pcl_front
    import pcl_pkg::*;
#(
    parameter int CAPACITY = CAP_DEFAULT,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [1:0]       req_mode,
    input  logic [POS_W-1:0] req_position,
    input  logic [VAL_W-1:0] req_value,
    output logic             push_valid,
    input  logic             push_ready,
    output cmd_t             push_cmd,
    output logic [CNT_W-1:0] fill_count
);

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CMP_W-1:0] pos_ext, cnt_ext;
    logic             full, rank_ok, push, grow, shrink;

    assign pos_ext    = CMP_W'(req_position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign rank_ok    = (req_position != '0) && (pos_ext <= cnt_ext);
    assign req_ready  = push_ready;
    assign push_valid = req_valid;
    assign push       = req_valid && push_ready;
    assign fill_count = count_reg;

    always_comb begin
        push_cmd = '{op: OP_STATUS, slot: req_position, value: req_value, status: ST_BADPOS};
        grow     = 1'b0;
        shrink   = 1'b0;
        unique case (mode_t'(req_mode))
            MODE_ADD: begin
                if (full) begin
                    push_cmd.status = ST_FULL;
                end else if (pos_ext <= cnt_ext + CMP_W'(1)) begin
                    push_cmd.op   = OP_INSERT;
                    push_cmd.slot = (req_position <= POS_W'(1)) ? '0
                                                                 : req_position - POS_W'(1);
                    grow          = 1'b1;
                end
            end
            MODE_DELETE: begin
                if (rank_ok) begin
                    push_cmd.op   = OP_REMOVE;
                    push_cmd.slot = req_position - POS_W'(1);
                    shrink        = 1'b1;
                end
            end
            MODE_GET: begin
                if (rank_ok) begin
                    push_cmd.op   = OP_GET;
                    push_cmd.slot = req_position - POS_W'(1);
                end
            end
            MODE_PRINT: begin
                if (count_reg == '0) begin
                    push_cmd.status = ST_EMPTY;
                end else begin
                    push_cmd.op = OP_PRINT;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (push && grow) begin
            count_next = count_reg + CNT_W'(1);
        end else if (push && shrink) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

### rtl/pcl_queue.sv
// Two-entry command queue between classifier and executor.
module pcl_queue
    import pcl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] used_reg, used_next;
    logic       wr, rd;

    assign in_ready  = (used_reg != 2'd2);
    assign out_valid = (used_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd ? ~rd_ptr_reg : rd_ptr_reg;
        used_next   = used_reg;
        if (wr && !rd) begin
            used_next = used_reg + 2'd1;
        end else if (rd && !wr) begin
            used_next = used_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            used_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

endmodule

### rtl/pcl_back.sv
// Executor: shifting entry store, print sequencer and result register.
module pcl_back
    import pcl_pkg::*;
#(
    parameter int CAPACITY = CAP_DEFAULT,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    input  cmd_t             cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [VAL_W-1:0] res_value,
    output logic [1:0]       res_status,
    output logic             res_last
);

    logic [VAL_W-1:0] store_reg [CAPACITY];
    logic [VAL_W-1:0] store_next [CAPACITY];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] m_value_reg, m_value_next;
    status_t          m_status_reg, m_status_next;
    logic             m_last_reg, m_last_next;

    logic [IDX_W-1:0] slot, rd_addr;
    logic [VAL_W-1:0] rd_data;
    logic             can_emit, print_end;

    assign slot      = cmd.slot[IDX_W-1:0];
    assign rd_addr   = (cmd.op == OP_PRINT) ? idx_reg : slot;
    assign rd_data   = store_reg[rd_addr];
    assign can_emit  = !m_valid_reg || res_ready;
    assign print_end = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_comb begin
        store_next    = store_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        cmd_pop       = 1'b0;
        m_valid_next  = m_valid_reg && !res_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        if (cmd_valid) begin
            unique case (cmd.op) inside
                OP_INSERT: begin
                    for (int j = 0; j < CAPACITY; j++) begin
                        if (IDX_W'(j) == slot) begin
                            store_next[j] = cmd.value;
                        end else if (j > 0 && IDX_W'(j) > slot) begin
                            store_next[j] = store_reg[(j > 0) ? j - 1 : 0];
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                    cmd_pop    = 1'b1;
                end
                OP_REMOVE: begin
                    for (int j = 0; j < CAPACITY - 1; j++) begin
                        if (IDX_W'(j) >= slot) begin
                            store_next[j] = store_reg[j + 1];
                        end
                    end
                    count_next = count_reg - CNT_W'(1);
                    cmd_pop    = 1'b1;
                end
                OP_GET, OP_STATUS: begin
                    if (can_emit) begin
                        m_valid_next  = 1'b1;
                        m_value_next  = (cmd.op == OP_GET) ? rd_data : '0;
                        m_status_next = (cmd.op == OP_GET) ? ST_ELEM : cmd.status;
                        m_last_next   = 1'b1;
                        cmd_pop       = 1'b1;
                    end
                end
                OP_PRINT: begin
                    if (can_emit) begin
                        m_valid_next  = 1'b1;
                        m_value_next  = rd_data;
                        m_status_next = ST_ELEM;
                        m_last_next   = print_end;
                        if (print_end) begin
                            idx_next = '0;
                            cmd_pop  = 1'b1;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                end
                default: cmd_pop = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        store_reg    <= store_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign res_valid  = m_valid_reg;
    assign res_value  = m_value_reg;
    assign res_status = m_status_reg;
    assign res_last   = m_last_reg;

endmodule

### rtl/positional_char_list.sv
// Top level of the positional character list: classifier, queue, executor.
//
// A bounded ordered list of bytes addressed by one-based rank. Each request
// on s_* is add (insert at a rank, ranks 0 and 1 meaning the front), delete,
// get, or print. The front end checks the rank and the fill level against
// its own copy of the entry count, so a request is classified the cycle it
// is accepted, and hands a command into a two-entry queue; s_ready is low
// only while that queue is full. The back end executes one command at a time
// on a row of byte registers that shift in parallel: an add or a delete
// gives no result, a get or any error gives one result, and a print gives
// one result per stored entry, in list order with m_last on the final one
// (a print of an empty list gives one "list empty" result). Results sit in
// an output register, so adds and deletes go on while one waits on m_ready;
// gets, errors and prints wait for it. Sustained rate is thus one request
// per cycle while m_ready keeps up, except that a print holds the back end
// until its last entry is given. Status codes: 0 element, 1 invalid
// position, 2 list empty, 3 list full (an add to a full list is dropped).
`include "positional_char_list_defines.svh"

module positional_char_list
    import pcl_pkg::*;
#(
    parameter int CAPACITY = CAP_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    input  logic [POS_W-1:0] s_position,
    input  logic [VAL_W-1:0] s_value_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VAL_W-1:0] m_value_out,
    output logic [1:0]       m_status,
    output logic             m_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // classified commands, front to back
    logic             push_valid, push_ready;
    cmd_t             push_cmd;
    logic             q_valid, q_pop;
    cmd_t             q_cmd;
    logic [CNT_W-1:0] fill_count;

    pcl_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_valid),
        .req_ready    (s_ready),
        .req_mode     (s_mode),
        .req_position (s_position),
        .req_value    (s_value_in),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd),
        .fill_count   (fill_count)
    );

    pcl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_cmd   (q_cmd)
    );

    pcl_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (q_valid),
        .cmd_pop    (q_pop),
        .cmd        (q_cmd),
        .res_valid  (m_valid),
        .res_ready  (m_ready),
        .res_value  (m_value_out),
        .res_status (m_status),
        .res_last   (m_last)
    );

    // the classifier's count never passes the capacity
    `PCL_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1,
        fill_count <= CNT_W'(CAPACITY), "entry count above capacity")

    // status results carry a zero byte
    `PCL_ASSERT_NOW(a_status_zero, aclk, aresetn, m_valid && (m_status != ST_ELEM),
        m_value_out == '0, "status result with nonzero value")

    // every status result is the only result of its request
    `PCL_ASSERT_NOW(a_status_last, aclk, aresetn, m_valid && (m_status != ST_ELEM),
        m_last, "status result without last")

endmodule

### bench/positional_char_list_tb.sv
// Self-checking testbench for the positional character list.
module positional_char_list_tb;
    import pcl_pkg::*;

    localparam int LIST_CAP       = CAP_DEFAULT;
    localparam int MAX_RANK       = (1 << POS_W) - 1;
    // The slowest legal run has about 140 requests, each a print of a full
    // list, behind a receiver that stalls most cycles. The limit is many times that.
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RAND_PER_PHASE = 20;
    localparam int SETTLE_CYCLES  = 40;

    // One request as the sender sees it.
    typedef struct {
        mode_t            mode;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } list_req_t;

    // One result, as predicted.
    typedef struct {
        logic [VAL_W-1:0] value;
        status_t          status;
        logic             last;
    } list_result_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    wire              s_ready;
    logic [1:0]       s_mode      = '0;
    logic [POS_W-1:0] s_position  = '0;
    logic [VAL_W-1:0] s_value_in  = '0;
    wire              m_valid;
    logic             m_ready     = 1'b0;
    wire  [VAL_W-1:0] m_value_out;
    wire  [1:0]       m_status;
    wire              m_last;

    // Requests not yet offered, and results the list still owes us.
    list_req_t    req_queue[$];
    list_result_t owed_results[$];

    // Our own copy of the list, advanced on every accepted request.
    logic [VAL_W-1:0] list_bytes [LIST_CAP];
    int               list_len = 0;
    int               peak_len = 0;

    // Entry count as seen while generating stimulus (ahead of the list itself).
    int gen_len     = 0;
    int phase_items = 0;

    // Flow-control knobs, in percent.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int req_count    = 0;
    int result_count = 0;
    int err_count    = 0;
    int cycle_count  = 0;
    int status_hits [4];

    list_req_t    next_req;
    list_req_t    taken_req;
    list_result_t want;

    always #1 aclk = ~aclk;

    positional_char_list #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_position (s_position),
        .s_value_in (s_value_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value_out(m_value_out),
        .m_status   (m_status),
        .m_last     (m_last)
    );

    function automatic void owe_result(input logic [VAL_W-1:0] value, input status_t status,
                                       input logic last);
        list_result_t r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        owed_results.push_back(r);
    endfunction

    // Apply one accepted request to our list and queue what it must produce.
    task automatic predict_request(input list_req_t req);
        int rank;
        int slot;
        int i;
        rank = int'(req.pos);
        case (req.mode)
            MODE_ADD: begin
                // Full wins over a bad rank.
                if (list_len >= LIST_CAP) begin
                    owe_result('0, ST_FULL, 1'b1);
                end else if (rank > list_len + 1) begin
                    owe_result('0, ST_BADPOS, 1'b1);
                end else begin
                    // Ranks 0 and 1 both mean the front.
                    slot = (rank <= 1) ? 0 : rank - 1;
                    for (i = list_len; i > slot; i--)
                        list_bytes[i] = list_bytes[i-1];
                    list_bytes[slot] = req.val;
                    list_len++;
                    if (list_len > peak_len)
                        peak_len = list_len;
                end
            end
            MODE_DELETE: begin
                if (rank == 0 || rank > list_len) begin
                    owe_result('0, ST_BADPOS, 1'b1);
                end else begin
                    for (i = rank - 1; i + 1 < list_len; i++)
                        list_bytes[i] = list_bytes[i+1];
                    list_len--;
                end
            end
            MODE_GET: begin
                if (rank == 0 || rank > list_len)
                    owe_result('0, ST_BADPOS, 1'b1);
                else
                    owe_result(list_bytes[rank-1], ST_ELEM, 1'b1);
            end
            default: begin
                // Print: every entry in order, or one empty status.
                if (list_len == 0) begin
                    owe_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (i = 0; i < list_len; i++)
                        owe_result(list_bytes[i], ST_ELEM, i + 1 == list_len);
                end
            end
        endcase
    endtask

    // Queue a request and track the entry count it leaves behind.
    task automatic queue_req(input mode_t mode, input int rank, input int value);
        list_req_t r;
        r.mode = mode;
        r.pos  = rank[POS_W-1:0];
        r.val  = value[VAL_W-1:0];
        req_queue.push_back(r);
        phase_items++;
        case (mode)
            MODE_ADD:    if (gen_len < LIST_CAP && rank <= gen_len + 1) gen_len++;
            MODE_DELETE: if (rank >= 1 && rank <= gen_len) gen_len--;
            default:     ;
        endcase
    endtask

    // Fill to capacity, bounce two adds off the full list, then print it all.
    task automatic queue_fill_run;
        while (gen_len < LIST_CAP)
            queue_req(MODE_ADD, $urandom_range(0, gen_len + 1), $urandom_range(0, 255));
        queue_req(MODE_ADD, $urandom_range(0, MAX_RANK), $urandom_range(0, 255));
        queue_req(MODE_ADD, MAX_RANK, $urandom_range(0, 255));
        queue_req(MODE_PRINT, $urandom_range(0, MAX_RANK), $urandom_range(0, 255));
    endtask

    // Empty the list by random deletes with some gets mixed in, then print.
    task automatic queue_drain_run;
        while (gen_len > 0) begin
            if ($urandom_range(0, 3) == 0)
                queue_req(MODE_GET, $urandom_range(1, gen_len), $urandom_range(0, 255));
            else
                queue_req(MODE_DELETE, $urandom_range(1, gen_len), $urandom_range(0, 255));
        end
        queue_req(MODE_PRINT, $urandom_range(0, MAX_RANK), $urandom_range(0, 255));
    endtask

    // Any operation; mostly good ranks, a quarter of them out of range.
    task automatic queue_mixed_req;
        mode_t m;
        int    rank;
        bit    bad;
        m   = mode_t'($urandom_range(0, 3));
        bad = ($urandom_range(0, 3) == 0);
        case (m)
            MODE_ADD: begin
                if (bad)
                    rank = $urandom_range(gen_len + 2, MAX_RANK);
                else
                    rank = $urandom_range(0, gen_len + 1);
            end
            MODE_PRINT: rank = $urandom_range(0, MAX_RANK);
            default: begin
                if (bad || gen_len == 0)
                    rank = ($urandom_range(0, 1) == 0) ? 0
                                                       : $urandom_range(gen_len + 1, MAX_RANK);
                else
                    rank = $urandom_range(1, gen_len);
            end
        endcase
        queue_req(m, rank, $urandom_range(0, 255));
    endtask

    // Driver: predicts each accepted request, then offers the next one
    // unless this cycle is drawn idle. Payload holds while valid waits.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                taken_req.mode = mode_t'(s_mode);
                taken_req.pos  = s_position;
                taken_req.val  = s_value_in;
                predict_request(taken_req);
                req_count++;
            end
            if (!s_valid || s_ready) begin
                if (req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = req_queue.pop_front();
                    s_valid    <= 1'b1;
                    s_mode     <= next_req.mode;
                    s_position <= next_req.pos;
                    s_value_in <= next_req.val;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: every accepted result against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result: value %0d status %0d last %0d",
                         $time, m_value_out, m_status, m_last);
                err_count++;
            end else begin
                want = owed_results.pop_front();
                status_hits[want.status]++;
                if (m_value_out !== want.value || m_status !== want.status
                        || m_last !== want.last) begin
                    $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             $time, want.value, want.status, want.last,
                             m_value_out, m_status, m_last);
                    err_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still owed", $time, owed_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 4; k++)
            status_hits[k] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Four flow-control phases: free-flowing, sender mostly idle,
        // receiver mostly stalled, and both idling a little.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase

            if (ph == 0) begin
                // Empty list: print, and every rank error on get and delete.
                queue_req(MODE_PRINT, 0, 0);
                queue_req(MODE_GET, 0, 8'hff);
                queue_req(MODE_GET, 1, 0);
                queue_req(MODE_DELETE, 1, 0);
                queue_req(MODE_DELETE, 0, 0);
                // Adds past the end of an empty list.
                queue_req(MODE_ADD, 2, 8'h11);
                queue_req(MODE_ADD, MAX_RANK, 8'hff);
                // Rank 0 and rank 1 both land at the front.
                queue_req(MODE_ADD, 0, 8'h00);
                queue_req(MODE_ADD, 1, 8'hff);
                // Append at count+1, then insert in the middle.
                queue_req(MODE_ADD, 3, 8'ha5);
                queue_req(MODE_ADD, 2, 8'h5a);
                queue_req(MODE_PRINT, MAX_RANK, 8'hff);
                queue_req(MODE_GET, 1, 0);
                queue_req(MODE_GET, 4, 0);
                queue_req(MODE_GET, 5, 0);
                queue_req(MODE_GET, 0, 0);
                // Delete from the back, the front, and far out of range.
                queue_req(MODE_DELETE, 4, 0);
                queue_req(MODE_DELETE, 1, 0);
                queue_req(MODE_DELETE, MAX_RANK, 0);
                queue_req(MODE_PRINT, 0, 0);
                queue_req(MODE_DELETE, 1, 0);
                queue_req(MODE_DELETE, 1, 0);
                queue_req(MODE_PRINT, 0, 0);
                // Make sure the full case is reached at least once.
                phase_items = 0;
                queue_fill_run();
            end else begin
                phase_items = 0;
            end

            // Random part: mostly short runs of mixed requests, now and
            // then a fill to capacity or a drain to empty.
            while (phase_items < RAND_PER_PHASE) begin
                case ($urandom_range(0, 9))
                    0:       queue_fill_run();
                    1:       queue_drain_run();
                    default: repeat (5) queue_mixed_req();
                endcase
            end

            // Phase ends once everything sent has been answered.
            while (req_queue.size() != 0 || s_valid || owed_results.size() != 0)
                @(posedge aclk);
        end

        // Let stray results show up.
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (owed_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, owed_results.size());
            err_count++;
        end
        $display("Ran %0d requests through four flow-control phases, list peaked at %0d of %0d.",
                 req_count, peak_len, LIST_CAP);
        $display("Checked %0d results: %0d elements, %0d bad rank, %0d empty, %0d full.",
                 result_count, status_hits[ST_ELEM], status_hits[ST_BADPOS],
                 status_hits[ST_EMPTY], status_hits[ST_FULL]);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/pcl_pkg.sv
rtl/pcl_front.sv
rtl/pcl_queue.sv
rtl/pcl_back.sv
rtl/positional_char_list.sv
bench/positional_char_list_tb.sv
